### rtl/core/ttwp_pkg.sv
// shared constants for the streaming top-three selector
package ttwp_pkg;

    localparam int DEF_MAX_DIM     = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // number of ranked slots kept
    localparam int SLOT_COUNT = 3;
    localparam int RANK_W     = $clog2(SLOT_COUNT);

    // apb map: one 32-bit register per word
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

endpackage

### rtl/core/top_three_with_position.sv
// streaming top-three selector: keeps the three largest distinct values and their positions
//
//  channel   | direction | signals                                   | moves
//  ----------+-----------+-------------------------------------------+---------------------------
//  element   | in        | i_in_valid / o_in_ready, i_element_value  | one matrix element per item
//  result    | out       | o_out_valid / i_out_ready, o_rank ...     | one ranked slot per item
//  apb       | in/out    | psel penable pwrite paddr pwdata prdata   | row_count, column_count
//
// one element item is taken per cycle while o_in_ready is high; the three compares
// and the slot shift form the next values of the held-slot registers combinationally
// the last element of the matrix snapshots the list into the report buffer, which then
// drains three result items, one per cycle while i_out_ready is high
// while a report drains, non-final elements keep flowing; only the next final element
// waits until the report buffer frees (it may enter as the last result leaves)
// synchronous active-low reset empties the list, zeroes the position, sets both counts to 1
module top_three_with_position
    import ttwp_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    // position and dimension widths follow from MAX_DIM
    parameter int POS_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int DIM_W       = $clog2(MAX_DIM + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // element channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_element_value,

    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic        [RANK_W-1:0]      o_rank,
    output logic                          o_slot_valid,
    output logic signed [VALUE_WIDTH-1:0] o_best_value,
    output logic        [POS_W-1:0]       o_best_row,
    output logic        [POS_W-1:0]       o_best_column,
    output logic                          o_last_of_run,

    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic        [APB_ADDR_W-1:0]  paddr,
    input  logic        [APB_DATA_W-1:0]  pwdata,
    output logic        [APB_DATA_W-1:0]  prdata,
    output logic                          pready
);

    // position counters get one spare bit so that position + 1 can reach the count
    localparam int CNT_W = POS_W + 1;
    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(SLOT_COUNT - 1);

    // ---------------------------------------------------------------- configuration
    logic [DIM_W-1:0] r_row_count;
    logic [DIM_W-1:0] r_column_count;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= DIM_W'(1);
            r_column_count <= DIM_W'(1);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_ROW_COUNT:    r_row_count    <= pwdata[DIM_W-1:0];
                REG_COLUMN_COUNT: r_column_count <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_DATA_W'(r_row_count);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(r_column_count);
        endcase
    end

    // a count of zero acts as one, a count beyond MAX_DIM acts as MAX_DIM
    logic [CNT_W-1:0] eff_rows;
    logic [CNT_W-1:0] eff_cols;

    always_comb begin
        if (r_row_count == '0) begin
            eff_rows = CNT_W'(1);
        end else if (CNT_W'(r_row_count) > CNT_W'(MAX_DIM)) begin
            eff_rows = CNT_W'(MAX_DIM);
        end else begin
            eff_rows = CNT_W'(r_row_count);
        end
        if (r_column_count == '0) begin
            eff_cols = CNT_W'(1);
        end else if (CNT_W'(r_column_count) > CNT_W'(MAX_DIM)) begin
            eff_cols = CNT_W'(MAX_DIM);
        end else begin
            eff_cols = CNT_W'(r_column_count);
        end
    end

    // ---------------------------------------------------------------- position
    logic [POS_W-1:0] r_row_pos;
    logic [POS_W-1:0] r_col_pos;
    logic             col_wrap;
    logic             row_wrap;
    logic             ends_now;

    // wrap once position + 1 reaches or passes the count (counts may change mid-matrix)
    assign col_wrap = (CNT_W'(r_col_pos) + CNT_W'(1)) >= eff_cols;
    assign row_wrap = (CNT_W'(r_row_pos) + CNT_W'(1)) >= eff_rows;
    assign ends_now = col_wrap && row_wrap;

    // ---------------------------------------------------------------- held list
    logic                          r_held_valid  [SLOT_COUNT];
    logic signed [VALUE_WIDTH-1:0] r_held_value  [SLOT_COUNT];
    logic        [POS_W-1:0]       r_held_row    [SLOT_COUNT];
    logic        [POS_W-1:0]       r_held_column [SLOT_COUNT];

    logic                          n_held_valid  [SLOT_COUNT];
    logic signed [VALUE_WIDTH-1:0] n_held_value  [SLOT_COUNT];
    logic        [POS_W-1:0]       n_held_row    [SLOT_COUNT];
    logic        [POS_W-1:0]       n_held_column [SLOT_COUNT];

    // report buffer, one snapshot of the list
    logic                          r_rep_busy;
    logic        [RANK_W-1:0]      r_rep_idx;
    logic                          r_rep_valid   [SLOT_COUNT];
    logic signed [VALUE_WIDTH-1:0] r_rep_value   [SLOT_COUNT];
    logic        [POS_W-1:0]       r_rep_row     [SLOT_COUNT];
    logic        [POS_W-1:0]       r_rep_column  [SLOT_COUNT];

    logic in_take;
    logic out_take;
    logic rep_done;
    logic dup;
    logic gt [SLOT_COUNT];

    assign out_take = o_out_valid && i_out_ready;
    assign rep_done = out_take && (r_rep_idx == LAST_RANK);

    // only an element that closes the matrix needs the report buffer free
    assign o_in_ready = !r_rep_busy || !ends_now || rep_done;
    assign in_take    = i_in_valid && o_in_ready;

    // equal values are dropped; an empty slot or a smaller value yields its place
    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (r_held_valid[k] && (r_held_value[k] == i_element_value)) begin
                dup = 1'b1;
            end
            gt[k] = !r_held_valid[k] || (i_element_value > r_held_value[k]);
        end
    end

    // slots are sorted and filled from the top, so gt is false then true down the list:
    // the first true slot takes the new value and the ones below shift down by one
    always_comb begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            n_held_valid[k]  = r_held_valid[k];
            n_held_value[k]  = r_held_value[k];
            n_held_row[k]    = r_held_row[k];
            n_held_column[k] = r_held_column[k];
        end
        if (!dup) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (gt[k]) begin
                    if (k == 0 || !gt[(k == 0) ? 0 : k - 1]) begin
                        n_held_valid[k]  = 1'b1;
                        n_held_value[k]  = i_element_value;
                        n_held_row[k]    = r_row_pos;
                        n_held_column[k] = r_col_pos;
                    end else begin
                        n_held_valid[k]  = r_held_valid[k-1];
                        n_held_value[k]  = r_held_value[k-1];
                        n_held_row[k]    = r_held_row[k-1];
                        n_held_column[k] = r_held_column[k-1];
                    end
                end
            end
        end
    end

    // list payload follows the insert; valid bits carry the emptiness
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_held_value[k]  <= n_held_value[k];
                r_held_row[k]    <= n_held_row[k];
                r_held_column[k] <= n_held_column[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_held_valid[k] <= 1'b0;
            end
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (in_take) begin
            // closing element: list is handed to the report buffer and emptied
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_held_valid[k] <= ends_now ? 1'b0 : n_held_valid[k];
            end
            if (!col_wrap) begin
                r_col_pos <= r_col_pos + POS_W'(1);
            end else begin
                r_col_pos <= '0;
                r_row_pos <= row_wrap ? '0 : (r_row_pos + POS_W'(1));
            end
        end
    end

    // ---------------------------------------------------------------- report buffer
    always_ff @(posedge i_clk) begin
        if (in_take && ends_now) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_rep_valid[k]  <= n_held_valid[k];
                r_rep_value[k]  <= n_held_value[k];
                r_rep_row[k]    <= n_held_row[k];
                r_rep_column[k] <= n_held_column[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_busy <= 1'b0;
            r_rep_idx  <= '0;
        end else if (in_take && ends_now) begin
            // a new report may load in the cycle the old one finishes
            r_rep_busy <= 1'b1;
            r_rep_idx  <= '0;
        end else if (rep_done) begin
            r_rep_busy <= 1'b0;
            r_rep_idx  <= '0;
        end else if (out_take) begin
            r_rep_idx <= r_rep_idx + RANK_W'(1);
        end
    end

    // empty slots report zeros in value, row and column
    assign o_out_valid   = r_rep_busy;
    assign o_rank        = r_rep_idx;
    assign o_slot_valid  = r_rep_valid[r_rep_idx];
    assign o_best_value  = r_rep_valid[r_rep_idx] ? r_rep_value[r_rep_idx] : '0;
    assign o_best_row    = r_rep_valid[r_rep_idx] ? r_rep_row[r_rep_idx] : '0;
    assign o_best_column = r_rep_valid[r_rep_idx] ? r_rep_column[r_rep_idx] : '0;
    assign o_last_of_run = (r_rep_idx == LAST_RANK);

endmodule

### tb/testbench.sv
// self-checking testbench for the streaming top-three selector with positions
module testbench
    import ttwp_pkg::*;
;

    localparam int MAX_DIM       = DEF_MAX_DIM;
    localparam int VALUE_W       = DEF_VALUE_WIDTH;
    localparam int POS_W         = $clog2(MAX_DIM);
    localparam int DIM_W         = $clog2(MAX_DIM + 1);
    // generous bound: a few hundred items, each possibly delayed by idling
    localparam int CYCLE_LIMIT   = 400000;
    // spare settling after the queues drain covers anything still in flight
    localparam int SETTLE_CYCLES = 8;
    localparam int RESET_CYCLES  = 6;

    localparam logic [APB_ADDR_W-1:0] ADDR_ROW_COUNT    = {REG_ROW_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_COLUMN_COUNT = {REG_COLUMN_COUNT, 2'b00};

    // one ranked slot of a report, as the result channel carries it
    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic               used;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   column;
        logic               last;
    } ranked_slot_t;

    // clock, reset and every block input start at known values
    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_in_valid      = 1'b0;
    logic signed [VALUE_W-1:0] i_element_value = '0;
    logic                      i_out_ready     = 1'b0;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr           = '0;
    logic [APB_DATA_W-1:0]     pwdata          = '0;

    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [RANK_W-1:0]         o_rank;
    logic                      o_slot_valid;
    logic signed [VALUE_W-1:0] o_best_value;
    logic [POS_W-1:0]          o_best_row;
    logic [POS_W-1:0]          o_best_column;
    logic                      o_last_of_run;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    top_three_with_position dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rank          (o_rank),
        .o_slot_valid    (o_slot_valid),
        .o_best_value    (o_best_value),
        .o_best_row      (o_best_row),
        .o_best_column   (o_best_column),
        .o_last_of_run   (o_last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // period of 12 time units
    always #6 i_clk = ~i_clk;

    // element items waiting to be driven, ranked slots still to come out
    logic [VALUE_W-1:0] pending_elements [$];
    ranked_slot_t       expected_slots [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // set at each rising edge when an element item is taken
    bit          element_taken  = 1'b0;

    // predictor copy of the list, the scan position and the two count registers
    logic signed [VALUE_W-1:0] held_value  [SLOT_COUNT];
    logic                      held_used   [SLOT_COUNT];
    logic [POS_W-1:0]          held_row    [SLOT_COUNT];
    logic [POS_W-1:0]          held_column [SLOT_COUNT];
    int unsigned               row_pos = 0;
    int unsigned               col_pos = 0;
    logic [DIM_W-1:0]          row_count_reg = 1;
    logic [DIM_W-1:0]          col_count_reg = 1;

    // a count of zero acts as one, anything past the maximum acts as the maximum
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return raw;
    endfunction

    task automatic clear_slots();
        for (int k = 0; k < SLOT_COUNT; k++) begin
            held_value[k]  = '0;
            held_used[k]   = 1'b0;
            held_row[k]    = '0;
            held_column[k] = '0;
        end
    endtask

    // takes one element into the list, advances the position and, on the final
    // element of the matrix, queues the three ranked slots and empties the list
    task automatic rank_element(input logic signed [VALUE_W-1:0] v);
        bit           dup;
        int           slot;
        int unsigned  rows;
        int unsigned  cols;
        ranked_slot_t r;
        dup  = 1'b0;
        slot = SLOT_COUNT;
        rows = clamp_dim(row_count_reg);
        cols = clamp_dim(col_count_reg);
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (held_used[k] && held_value[k] == v) dup = 1'b1;
        end
        // lowest rank that is empty or holds a smaller value
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!held_used[k] || v > held_value[k]) slot = k;
        end
        if (!dup && slot < SLOT_COUNT) begin
            for (int j = SLOT_COUNT - 1; j > slot; j--) begin
                held_value[j]  = held_value[j-1];
                held_used[j]   = held_used[j-1];
                held_row[j]    = held_row[j-1];
                held_column[j] = held_column[j-1];
            end
            held_value[slot]  = v;
            held_used[slot]   = 1'b1;
            held_row[slot]    = row_pos[POS_W-1:0];
            held_column[slot] = col_pos[POS_W-1:0];
        end
        // wrap tests use >= so counts lowered mid-matrix wrap at once
        if (col_pos + 1 < cols) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < rows) begin
            row_pos++;
            return;
        end
        row_pos = 0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            r.rank   = k[RANK_W-1:0];
            r.used   = held_used[k];
            r.value  = held_used[k] ? held_value[k] : '0;
            r.row    = held_used[k] ? held_row[k] : '0;
            r.column = held_used[k] ? held_column[k] : '0;
            r.last   = (k == SLOT_COUNT - 1);
            expected_slots.push_back(r);
        end
        clear_slots();
    endtask

    // only the first ten mismatches are printed, the rest are counted
    task automatic note_mismatch(input string msg);
        if (mismatch_count < 10) $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0h actual %0h", what, want, got));
    endtask

    // setup cycle then access cycle; a write updates the predictor's register,
    // a read is checked against it
    task automatic apb_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (is_write) begin
            if (addr[2] == REG_COLUMN_COUNT) col_count_reg = data[DIM_W-1:0];
            else row_count_reg = data[DIM_W-1:0];
        end else begin
            want = (addr[2] == REG_COLUMN_COUNT) ? APB_DATA_W'(col_count_reg)
                                                 : APB_DATA_W'(row_count_reg);
            check_field($sformatf("readback at %0h", addr), want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block idle: nothing left to send, nothing in flight, nothing expected
    task automatic wait_quiet();
        while (pending_elements.size() != 0 || i_in_valid || expected_slots.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // mix of extremes, small values that collide often, and full-range values
    function automatic logic [VALUE_W-1:0] draw_element();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 8) - 4;
            default: return $urandom();
        endcase
    endfunction

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // element driver: valid holds with its payload until the item is taken
    always @(negedge i_clk) begin
        if (!i_in_valid || element_taken) begin
            if (pending_elements.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid      <= 1'b1;
                i_element_value <= pending_elements.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver: ready toggles independently of valid
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on each element item taken, then check each result item
    always @(posedge i_clk) begin : monitor
        ranked_slot_t want;
        element_taken = i_rst_n && i_in_valid && o_in_ready;
        if (element_taken) rank_element(i_element_value);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_slots.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected, rank %0d", o_rank));
            end else begin
                want = expected_slots.pop_front();
                check_field("rank", want.rank, o_rank);
                check_field("slot_valid", want.used, o_slot_valid);
                check_field("best_value", want.value, o_best_value);
                check_field("best_row", want.row, o_best_row);
                check_field("best_column", want.column, o_best_column);
                check_field("last_of_run", want.last, o_last_of_run);
            end
        end
    end

    initial begin : stimulus
        int unsigned mode;
        int unsigned len;
        int unsigned n;
        bit          hold_off;
        clear_slots();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both counts come out of reset at one
        apb_access(1'b0, ADDR_ROW_COUNT, '0);
        apb_access(1'b0, ADDR_COLUMN_COUNT, '0);

        // one-element matrices: each extreme of the value range reported alone,
        // a negative value must still enter an empty slot
        pending_elements.push_back(32'h7FFF_FFFF);
        pending_elements.push_back(32'h8000_0000);
        pending_elements.push_back(32'hFFFF_FFFF);
        pending_elements.push_back(32'h0000_0000);
        wait_quiet();

        // 2x3 matrix with repeated values, negatives and the most negative value
        apb_access(1'b1, ADDR_ROW_COUNT, 2);
        apb_access(1'b1, ADDR_COLUMN_COUNT, 3);
        pending_elements.push_back(-5);
        pending_elements.push_back(-5);
        pending_elements.push_back(7);
        pending_elements.push_back(3);
        pending_elements.push_back(7);
        pending_elements.push_back(32'h8000_0000);
        // a matrix of one repeated value leaves two ranks empty
        repeat (6) pending_elements.push_back(42);
        wait_quiet();

        // zero counts, written with the unused upper bits set, act as one
        apb_access(1'b1, ADDR_ROW_COUNT, 32'hFFFF_F800);
        apb_access(1'b1, ADDR_COLUMN_COUNT, 32'hFFFF_F800);
        apb_access(1'b0, ADDR_ROW_COUNT, '0);
        apb_access(1'b0, ADDR_COLUMN_COUNT, '0);
        pending_elements.push_back(123);
        wait_quiet();

        // column count lowered below the current column mid-matrix: wraps at once
        apb_access(1'b1, ADDR_ROW_COUNT, 1);
        apb_access(1'b1, ADDR_COLUMN_COUNT, 4);
        pending_elements.push_back(10);
        pending_elements.push_back(-20);
        pending_elements.push_back(30);
        wait_quiet();
        apb_access(1'b1, ADDR_COLUMN_COUNT, 2);
        pending_elements.push_back(5);
        wait_quiet();

        // counts past the maximum: rows, then columns, do not wrap early; lowering
        // the count afterwards ends the matrix at once on the largest element
        for (int big = 0; big < 2; big++) begin
            apb_access(1'b1, ADDR_ROW_COUNT, big == 0 ? 32'h0000_07FF : 32'h1);
            apb_access(1'b1, ADDR_COLUMN_COUNT, big == 0 ? 32'h1 : 32'hFFFF_FFFF);
            apb_access(1'b0, big == 0 ? ADDR_ROW_COUNT : ADDR_COLUMN_COUNT, '0);
            repeat (15) pending_elements.push_back($urandom() & 32'h7FFF_FFFE);
            wait_quiet();
            apb_access(1'b1, big == 0 ? ADDR_ROW_COUNT : ADDR_COLUMN_COUNT, 32'h2);
            pending_elements.push_back(32'h7FFF_FFFF);
            wait_quiet();
        end

        // random part: four idling styles, two small shapes each; leftovers carry
        // a partial matrix across the count change
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            // in two of the styles the sender sometimes holds off until all is out
            hold_off = (mode == 0 || mode == 3);
            for (int shape = 0; shape < 2; shape++) begin
                wait_quiet();
                apb_access(1'b1, ADDR_ROW_COUNT,
                           ($urandom() & 32'hFFFF_F800) | $urandom_range(0, 5));
                apb_access(1'b1, ADDR_COLUMN_COUNT,
                           ($urandom() & 32'hFFFF_F800) | $urandom_range(0, 5));
                len = clamp_dim(row_count_reg) * clamp_dim(col_count_reg);
                n = 0;
                while (n < 40) begin
                    if (hold_off && $urandom_range(0, 2) == 0) wait_quiet();
                    repeat (len) pending_elements.push_back(draw_element());
                    n += len;
                end
                repeat ($urandom_range(0, len - 1)) pending_elements.push_back(draw_element());
            end
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
